[rtl/mcx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcx_pkg
// Shared types, constants and the control program of the max-cut search.
// ----------------------------------------------------------------------------
package mcx_pkg;

	localparam int DEF_MAX_NODES   = 16;
	localparam int DEF_WEIGHT_BITS = 8;

	localparam int CUT_W      = 14;
	localparam int NCNT_W     = 5;
	localparam int IDX_W      = 4;
	localparam int IN_WGT_W   = 8;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam int PC_W       = 3;
	localparam int COND_W     = 3;

	localparam logic [CUT_W-1:0]  CUT_MAX        = '1;
	localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 5'd16;

	localparam logic [PADDR_W-3:0] REG_NODE_COUNT = 1'd0;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	localparam logic [PC_W-1:0] P_CLEAR = 3'd0;
	localparam logic [PC_W-1:0] P_IDLE  = 3'd1;
	localparam logic [PC_W-1:0] P_INIT  = 3'd2;
	localparam logic [PC_W-1:0] P_SCAN  = 3'd3;
	localparam logic [PC_W-1:0] P_DRAIN = 3'd4;
	localparam logic [PC_W-1:0] P_CMP   = 3'd5;
	localparam logic [PC_W-1:0] P_EMIT  = 3'd6;

	localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
	localparam logic [COND_W-1:0] C_SOLVE     = 3'd1;
	localparam logic [COND_W-1:0] C_IJ_LAST   = 3'd2;
	localparam logic [COND_W-1:0] C_MASK_LAST = 3'd3;
	localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd4;

	typedef struct packed {
		logic in_rdy;
		logic mem_clr;
		logic rd_en;
		logic ij_clr;
		logic ij_inc;
		logic full_range;
		logic acc_clr;
		logic best_clr;
		logic best_upd;
		logic mask_clr;
		logic mask_inc;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		ctrl_t             ctrl;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   t_pc;
		logic [PC_W-1:0]   f_pc;
	} uword_t;

	typedef struct packed {
		logic ij_last;
		logic mask_last;
	} dp_stat_t;

	typedef struct packed {
		logic solve_acc;
		logic ij_last;
		logic mask_last;
		logic out_free;
	} cond_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		case (pc)
			P_CLEAR: begin
				w.ctrl.mem_clr    = 1'b1;
				w.ctrl.ij_inc     = 1'b1;
				w.ctrl.full_range = 1'b1;
				w.cond = C_IJ_LAST;
				w.t_pc = P_IDLE;
				w.f_pc = P_CLEAR;
			end
			P_IDLE: begin
				w.ctrl.in_rdy = 1'b1;
				w.cond = C_SOLVE;
				w.t_pc = P_INIT;
				w.f_pc = P_IDLE;
			end
			P_INIT: begin
				w.ctrl.ij_clr   = 1'b1;
				w.ctrl.acc_clr  = 1'b1;
				w.ctrl.best_clr = 1'b1;
				w.ctrl.mask_clr = 1'b1;
				w.cond = C_ALWAYS;
				w.t_pc = P_SCAN;
				w.f_pc = P_SCAN;
			end
			P_SCAN: begin
				w.ctrl.rd_en  = 1'b1;
				w.ctrl.ij_inc = 1'b1;
				w.cond = C_IJ_LAST;
				w.t_pc = P_DRAIN;
				w.f_pc = P_SCAN;
			end
			P_DRAIN: begin
				w.cond = C_ALWAYS;
				w.t_pc = P_CMP;
				w.f_pc = P_CMP;
			end
			P_CMP: begin
				w.ctrl.best_upd = 1'b1;
				w.ctrl.acc_clr  = 1'b1;
				w.ctrl.mask_inc = 1'b1;
				w.cond = C_MASK_LAST;
				w.t_pc = P_EMIT;
				w.f_pc = P_SCAN;
			end
			P_EMIT: begin
				w.ctrl.out_load = 1'b1;
				w.cond = C_OUT_FREE;
				w.t_pc = P_IDLE;
				w.f_pc = P_EMIT;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.t_pc = P_IDLE;
				w.f_pc = P_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/mcx_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcx_seq
// Step counter over the control program, with conditional jumps.
// ----------------------------------------------------------------------------
module mcx_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  mcx_pkg::cond_t cond,
	output mcx_pkg::ctrl_t ctrl
);
	import mcx_pkg::*;

	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            take;

	always_comb begin
		uw = ucode(pc_q);
		case (uw.cond)
			C_ALWAYS:    take = 1'b1;
			C_SOLVE:     take = cond.solve_acc;
			C_IJ_LAST:   take = cond.ij_last;
			C_MASK_LAST: take = cond.mask_last;
			C_OUT_FREE:  take = cond.out_free;
			default:     take = 1'b1;
		endcase
	end

	assign ctrl = uw.ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_CLEAR;
		end else begin
			pc_q <= take ? uw.t_pc : uw.f_pc;
		end
	end

endmodule

[rtl/mcx_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcx_dpath
// Weight memory, node and partition counters, cut accumulator, best value.
// ----------------------------------------------------------------------------
module mcx_dpath #(
	parameter int MAX_NODES   = mcx_pkg::DEF_MAX_NODES,
	parameter int WEIGHT_BITS = mcx_pkg::DEF_WEIGHT_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcx_pkg::ctrl_t              ctrl,
	input  logic [mcx_pkg::NCNT_W-1:0]  node_count,
	input  logic                        wr_en,
	input  logic [mcx_pkg::IDX_W-1:0]   wr_row,
	input  logic [mcx_pkg::IDX_W-1:0]   wr_col,
	input  logic [WEIGHT_BITS-1:0]      wr_weight,
	output mcx_pkg::dp_stat_t           stat,
	output logic [mcx_pkg::CUT_W-1:0]   best
);
	import mcx_pkg::*;

	localparam int DEPTH  = MAX_NODES * MAX_NODES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int WA_W   = ADDR_W + IDX_W + 1;
	localparam int SUM_W  = ((WEIGHT_BITS > CUT_W) ? WEIGHT_BITS : CUT_W) + 1;

	logic [WEIGHT_BITS-1:0] mem [DEPTH];

	logic [NODE_W-1:0]      i_q;
	logic [NODE_W-1:0]      j_q;
	logic [MAX_NODES-1:0]   mask_q;
	logic [CUT_W-1:0]       acc_q;
	logic [CUT_W-1:0]       best_q;
	logic                   add_en_s1;
	logic [WEIGHT_BITS-1:0] rd_s1;

	logic [NCNT_W-1:0]      n_eff;
	logic [NODE_W-1:0]      n_last;
	logic [NODE_W-1:0]      bound;
	logic                   j_end;
	logic [MAX_NODES:0]     lim_full;
	logic [ADDR_W-1:0]      rd_addr;
	logic [WA_W-1:0]        wa_full;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [WEIGHT_BITS-1:0] mem_wd;
	logic [SUM_W-1:0]       sum;
	logic [CUT_W-1:0]       acc_nxt;

	always_comb begin
		n_eff    = (node_count > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count;
		n_last   = (n_eff == '0) ? '0 : NODE_W'(n_eff - NCNT_W'(1));
		bound    = ctrl.full_range ? NODE_W'(MAX_NODES - 1) : n_last;
		j_end    = (j_q == bound);
		lim_full = ((MAX_NODES+1)'(1) << n_eff) - (MAX_NODES+1)'(1);

		stat.ij_last   = j_end && (i_q == bound);
		stat.mask_last = (mask_q == lim_full[MAX_NODES-1:0]);

		rd_addr = ADDR_W'(i_q) * ADDR_W'(MAX_NODES) + ADDR_W'(j_q);
		wa_full = WA_W'(wr_row) * WA_W'(MAX_NODES) + WA_W'(wr_col);

		mem_we = ctrl.mem_clr || wr_en;
		mem_wa = ctrl.mem_clr ? rd_addr : wa_full[ADDR_W-1:0];
		mem_wd = ctrl.mem_clr ? '0 : wr_weight;

		sum     = SUM_W'(acc_q) + SUM_W'(rd_s1);
		acc_nxt = (sum > SUM_W'(CUT_MAX)) ? CUT_MAX : sum[CUT_W-1:0];
	end

	assign best = best_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (ctrl.rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			mask_q    <= '0;
			acc_q     <= '0;
			best_q    <= '0;
			add_en_s1 <= 1'b0;
		end else begin
			add_en_s1 <= ctrl.rd_en && mask_q[i_q] && !mask_q[j_q];

			if (ctrl.ij_clr || (ctrl.ij_inc && stat.ij_last)) begin
				i_q <= '0;
				j_q <= '0;
			end else if (ctrl.ij_inc) begin
				if (j_end) begin
					j_q <= '0;
					i_q <= i_q + NODE_W'(1);
				end else begin
					j_q <= j_q + NODE_W'(1);
				end
			end

			if (ctrl.mask_clr) begin
				mask_q <= '0;
			end else if (ctrl.mask_inc) begin
				mask_q <= mask_q + MAX_NODES'(1);
			end

			if (ctrl.acc_clr) begin
				acc_q <= '0;
			end else if (add_en_s1) begin
				acc_q <= acc_nxt;
			end

			if (ctrl.best_clr) begin
				best_q <= '0;
			end else if (ctrl.best_upd && (acc_q > best_q)) begin
				best_q <= acc_q;
			end
		end
	end

endmodule

[rtl/max_cut_exhaustive_search_top.sv]
`timescale 1ns / 1ps
// Write items: one per cycle while in_stall is low, no result.
// Solve items: for n nodes, each of the 2^n partitions scans max(n,1)^2 matrix entries
// through the single weight-memory read port, one matrix entry per cycle; the cut
// value is loaded after the last partition.
// Reset: a clearing pass over all MAX_NODES*MAX_NODES entries zeroes the weight memory,
// input stalled meanwhile and during a solve until the result is loaded; node_count 16.
// ----------------------------------------------------------------------------
// max_cut_exhaustive_search_top
// Maximum-cut exhaustive search over a loaded edge weight matrix.
// ----------------------------------------------------------------------------
module max_cut_exhaustive_search_top #(
	parameter int MAX_NODES   = mcx_pkg::DEF_MAX_NODES,
	parameter int WEIGHT_BITS = mcx_pkg::DEF_WEIGHT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mcx_pkg::PADDR_W-1:0]   paddr,
	input  logic [mcx_pkg::PDATA_W-1:0]   pwdata,
	output logic [mcx_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [mcx_pkg::IDX_W-1:0]     row_node,
	input  logic [mcx_pkg::IDX_W-1:0]     col_node,
	input  logic [mcx_pkg::IN_WGT_W-1:0]  edge_weight,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mcx_pkg::CUT_W-1:0]     best_cut_value
);
	import mcx_pkg::*;

	localparam int WX_W = (WEIGHT_BITS > IN_WGT_W) ? WEIGHT_BITS : IN_WGT_W;

	ctrl_t                  ctrl;
	cond_t                  cond;
	dp_stat_t               stat;
	logic [NCNT_W-1:0]      node_count_q;
	logic                   out_valid_q;
	logic [CUT_W-1:0]       best_cut_value_q;
	logic [CUT_W-1:0]       best;
	logic                   in_acc;
	logic                   out_free;
	logic                   row_ok;
	logic                   wr_en;
	logic                   reg_hit;
	logic [WX_W-1:0]        w_ext;
	logic [WEIGHT_BITS-1:0] wr_weight;

	always_comb begin
		reg_hit   = (paddr[PADDR_W-1:2] == REG_NODE_COUNT);
		in_stall  = !ctrl.in_rdy;
		in_acc    = in_valid && !in_stall;
		out_free  = !out_valid_q || !out_stall;
		row_ok    = (NCNT_W'(row_node) < NCNT_W'(MAX_NODES))
			&& (NCNT_W'(col_node) < NCNT_W'(MAX_NODES));
		wr_en     = in_acc && (opcode == OP_WRITE) && row_ok;
		w_ext     = WX_W'(edge_weight);
		wr_weight = w_ext[WEIGHT_BITS-1:0];
		cond      = '{solve_acc: in_acc && (opcode == OP_SOLVE),
			ij_last: stat.ij_last, mask_last: stat.mask_last, out_free: out_free};
		prdata    = reg_hit ? PDATA_W'(node_count_q) : '0;
	end

	assign pready         = 1'b1;
	assign out_valid      = out_valid_q;
	assign best_cut_value = best_cut_value_q;

	mcx_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl)
	);

	mcx_dpath #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.node_count (node_count_q),
		.wr_en      (wr_en),
		.wr_row     (row_node),
		.wr_col     (col_node),
		.wr_weight  (wr_weight),
		.stat       (stat),
		.best       (best)
	);

	always_ff @(posedge clk) begin
		if (ctrl.out_load && out_free) begin
			best_cut_value_q <= best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && reg_hit) begin
				node_count_q <= pwdata[NCNT_W-1:0];
			end
			if (ctrl.out_load && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
